### rtl/rme_pkg.sv
package rme_pkg;

	localparam int DATA_W       = 32;
	localparam int REG_IDX_W    = 3;
	localparam int MODE_W       = 5;
	localparam int STATUS_W     = 2;
	localparam int REG_COUNT_DEF = 5;

	// Instruction codes.
	localparam logic [MODE_W-1:0] MODE_LOAD  = 5'd0;
	localparam logic [MODE_W-1:0] MODE_MOV   = 5'd1;
	localparam logic [MODE_W-1:0] MODE_ADD   = 5'd2;
	localparam logic [MODE_W-1:0] MODE_SUB   = 5'd3;
	localparam logic [MODE_W-1:0] MODE_MUL   = 5'd4;
	localparam logic [MODE_W-1:0] MODE_MOD   = 5'd5;
	localparam logic [MODE_W-1:0] MODE_DIV   = 5'd6;
	localparam logic [MODE_W-1:0] MODE_INC   = 5'd7;
	localparam logic [MODE_W-1:0] MODE_DEC   = 5'd8;
	localparam logic [MODE_W-1:0] MODE_EQ    = 5'd9;
	localparam logic [MODE_W-1:0] MODE_GE    = 5'd10;
	localparam logic [MODE_W-1:0] MODE_LE    = 5'd11;
	localparam logic [MODE_W-1:0] MODE_GOTO  = 5'd12;
	localparam logic [MODE_W-1:0] MODE_JZ    = 5'd13;
	localparam logic [MODE_W-1:0] MODE_JNZ   = 5'd14;
	localparam logic [MODE_W-1:0] MODE_SHIFT = 5'd15;
	localparam logic [MODE_W-1:0] MODE_NOP   = 5'd16;
	localparam logic [MODE_W-1:0] MODE_END   = 5'd17;
	localparam logic [MODE_W-1:0] MODE_INT   = 5'd18;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_CONT = 2'd0;
	localparam logic [STATUS_W-1:0] ST_END  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INT  = 2'd2;

	// Instruction byte sizes.
	localparam logic [DATA_W-1:0] SIZE_LONG  = 32'd9;
	localparam logic [DATA_W-1:0] SIZE_JUMP  = 32'd8;
	localparam logic [DATA_W-1:0] SIZE_REG2  = 32'd6;
	localparam logic [DATA_W-1:0] SIZE_REG1  = 32'd5;
	localparam logic [DATA_W-1:0] SIZE_SHORT = 32'd4;

	typedef enum logic [1:0] {
		MD_MUL = 2'd0,
		MD_DIV = 2'd1,
		MD_MOD = 2'd2
	} md_op_t;

	typedef struct packed {
		logic              start;
		md_op_t            op;
		logic [DATA_W-1:0] opa;
		logic [DATA_W-1:0] opb;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] result;
	} md_rsp_t;

endpackage

### rtl/rme_regfile.sv
module rme_regfile #(
	parameter int REG_COUNT = rme_pkg::REG_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [rme_pkg::REG_IDX_W-1:0]   rd_idx_a,
	input  logic [rme_pkg::REG_IDX_W-1:0]   rd_idx_b,
	output logic [rme_pkg::DATA_W-1:0]      rd_data_a,
	output logic [rme_pkg::DATA_W-1:0]      rd_data_b,
	input  logic                            wr_en,
	input  logic [rme_pkg::REG_IDX_W-1:0]   wr_idx,
	input  logic [rme_pkg::DATA_W-1:0]      wr_data
);

	localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int EW = rme_pkg::REG_IDX_W + AW;

	logic [rme_pkg::DATA_W-1:0] mem [REG_COUNT];
	logic [REG_COUNT-1:0]       valid_q;
	logic [rme_pkg::DATA_W-1:0] rd_a_q;
	logic [rme_pkg::DATA_W-1:0] rd_b_q;

	logic [EW-1:0] ext_a;
	logic [EW-1:0] ext_b;
	logic [EW-1:0] ext_w;
	logic          in_a;
	logic          in_b;
	logic          in_w;

	assign ext_a = {{AW{1'b0}}, rd_idx_a};
	assign ext_b = {{AW{1'b0}}, rd_idx_b};
	assign ext_w = {{AW{1'b0}}, wr_idx};
	assign in_a  = ext_a < EW'(REG_COUNT);
	assign in_b  = ext_b < EW'(REG_COUNT);
	assign in_w  = ext_w < EW'(REG_COUNT);

	// Registers that were never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en && in_w) begin
			valid_q[ext_w[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && in_w) begin
			mem[ext_w[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= (in_a && valid_q[ext_a[AW-1:0]]) ? mem[ext_a[AW-1:0]] : '0;
			rd_b_q <= (in_b && valid_q[ext_b[AW-1:0]]) ? mem[ext_b[AW-1:0]] : '0;
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

### rtl/rme_muldiv.sv
module rme_muldiv (
	input  logic             clk,
	input  logic             arst_n,
	input  rme_pkg::md_req_t req,
	output rme_pkg::md_rsp_t rsp
);

	localparam int W  = rme_pkg::DATA_W;
	localparam int CW = $clog2(W);

	logic           busy_q;
	logic           fin_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	rme_pkg::md_op_t op_q;
	logic           qneg_q;
	logic           rneg_q;
	logic [W-1:0]   x_q;
	logic [W-1:0]   y_q;
	logic [W-1:0]   acc_q;
	logic [W-1:0]   result_q;

	logic           is_mul;
	logic           sub;
	logic [W-1:0]   shifted;
	logic [W-1:0]   opnd;
	logic [W:0]     addend;
	logic [W:0]     sum;
	logic           fits;
	logic [W-1:0]   abs_a;
	logic [W-1:0]   abs_b;

	assign is_mul  = (op_q == rme_pkg::MD_MUL);
	assign sub     = !is_mul;
	assign shifted = {acc_q[W-2:0], y_q[W-1]};
	assign opnd    = is_mul ? acc_q : shifted;
	assign addend  = {1'b0, x_q} ^ {(W+1){sub}};
	// One shared adder: accumulate for multiply, trial subtract for divide.
	assign sum     = {1'b0, opnd} + addend + {{W{1'b0}}, sub};
	assign fits    = !sum[W];

	assign abs_a = req.opa[W-1] ? (~req.opa + 1'b1) : req.opa;
	assign abs_b = req.opb[W-1] ? (~req.opb + 1'b1) : req.opb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= rme_pkg::MD_MUL;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				op_q   <= req.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q  <= '0;
			qneg_q <= req.opa[W-1] ^ req.opb[W-1];
			rneg_q <= req.opa[W-1];
			if (req.op == rme_pkg::MD_MUL) begin
				x_q <= req.opa;
				y_q <= req.opb;
			end else begin
				x_q <= abs_b;
				y_q <= abs_a;
			end
		end else if (busy_q) begin
			if (is_mul) begin
				if (y_q[0]) begin
					acc_q <= sum[W-1:0];
				end
				x_q <= {x_q[W-2:0], 1'b0};
				y_q <= {1'b0, y_q[W-1:1]};
			end else if (fits) begin
				acc_q <= sum[W-1:0];
				y_q   <= {y_q[W-2:0], 1'b1};
			end else begin
				acc_q <= shifted;
				y_q   <= {y_q[W-2:0], 1'b0};
			end
		end
		if (fin_q) begin
			case (op_q)
				rme_pkg::MD_MUL: result_q <= acc_q;
				rme_pkg::MD_DIV: result_q <= qneg_q ? (~y_q + 1'b1) : y_q;
				rme_pkg::MD_MOD: result_q <= rneg_q ? (~acc_q + 1'b1) : acc_q;
				default:         result_q <= acc_q;
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

### rtl/register_machine_execute_unit_top.sv
// Executes one decoded instruction per input transaction on a small 32-bit register
// machine with REG_COUNT registers (register 0 is the accumulator) and a program
// counter, and returns one result transaction per instruction. The block takes one
// instruction at a time. A simple instruction passes from S_IDLE through S_EXEC to
// S_OUT, and the next instruction can be taken once its result has been accepted.
// Multiply, divide and remainder run one bit per cycle through a shared 32-step
// shift-add/subtract unit, waiting in S_WAIT until the unit reports done. A divide
// or remainder by zero leaves the accumulator unchanged and takes as long as a
// simple instruction. The code base register may be written at any time the block
// holds no instruction; it is added to jump targets.
module register_machine_execute_unit_top #(
	parameter int REG_COUNT = rme_pkg::REG_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rme_pkg::DATA_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rme_pkg::MODE_W-1:0]         mode,
	input  logic [rme_pkg::REG_IDX_W-1:0]      first_reg,
	input  logic [rme_pkg::REG_IDX_W-1:0]      second_reg,
	input  logic signed [rme_pkg::DATA_W-1:0]  immediate,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rme_pkg::STATUS_W-1:0]       status,
	output logic [rme_pkg::DATA_W-1:0]         next_pc,
	output logic signed [rme_pkg::DATA_W-1:0]  accumulator,
	output logic [rme_pkg::DATA_W-1:0]         interrupt_address
);

	localparam int W = rme_pkg::DATA_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_WAIT = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [rme_pkg::MODE_W-1:0]    mode_q;
	logic [rme_pkg::REG_IDX_W-1:0] r1_q;
	logic [rme_pkg::REG_IDX_W-1:0] r2_q;
	logic [W-1:0]                  imm_q;
	logic [W-1:0]                  code_base_q;
	logic [W-1:0]                  pc_q;
	logic [W-1:0]                  acc_q;
	logic [rme_pkg::STATUS_W-1:0]  status_q;
	logic [W-1:0]                  iaddr_q;

	logic                          accept;
	logic [W-1:0]                  a;
	logic [W-1:0]                  b;
	logic                          wr_en;
	logic [rme_pkg::REG_IDX_W-1:0] wr_idx;
	logic [W-1:0]                  wr_data;
	logic [W-1:0]                  pc_d;
	logic [rme_pkg::STATUS_W-1:0]  status_d;
	logic [W-1:0]                  iaddr_d;
	logic [W-1:0]                  shift_val;
	logic [W-1:0]                  neg_cnt;
	rme_pkg::md_req_t              md_req;
	rme_pkg::md_rsp_t              md_rsp;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	rme_regfile #(
		.REG_COUNT(REG_COUNT)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_idx_a (first_reg),
		.rd_idx_b (second_reg),
		.rd_data_a(a),
		.rd_data_b(b),
		.wr_en    (wr_en),
		.wr_idx   (wr_idx),
		.wr_data  (wr_data)
	);

	rme_muldiv u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.rsp   (md_rsp)
	);

	assign neg_cnt = '0 - imm_q;

	always_comb begin
		if (imm_q == '0) begin
			shift_val = b;
		end else if (!imm_q[W-1]) begin
			shift_val = (imm_q >= W'(W)) ? '0 : (b >> imm_q[4:0]);
		end else begin
			shift_val = (neg_cnt >= W'(W)) ? '0 : (b << neg_cnt[4:0]);
		end
	end

	always_comb begin
		state_d      = state_q;
		wr_en        = 1'b0;
		wr_idx       = r1_q;
		wr_data      = a;
		pc_d         = pc_q;
		status_d     = rme_pkg::ST_CONT;
		iaddr_d      = '0;
		md_req.start = 1'b0;
		md_req.op    = rme_pkg::MD_MUL;
		md_req.opa   = a;
		md_req.opb   = b;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_OUT;
				case (mode_q)
					rme_pkg::MODE_LOAD: begin
						wr_en   = 1'b1;
						wr_data = imm_q;
						pc_d    = pc_q + rme_pkg::SIZE_LONG;
					end
					rme_pkg::MODE_MOV: begin
						wr_en   = 1'b1;
						wr_data = b;
						pc_d    = pc_q + rme_pkg::SIZE_REG2;
					end
					rme_pkg::MODE_ADD: begin
						wr_en   = 1'b1;
						wr_idx  = '0;
						wr_data = a + b;
						pc_d    = pc_q + rme_pkg::SIZE_REG2;
					end
					rme_pkg::MODE_SUB: begin
						wr_en   = 1'b1;
						wr_idx  = '0;
						wr_data = a - b;
						pc_d    = pc_q + rme_pkg::SIZE_REG2;
					end
					rme_pkg::MODE_MUL: begin
						md_req.start = 1'b1;
						md_req.op    = rme_pkg::MD_MUL;
						state_d      = S_WAIT;
						pc_d         = pc_q + rme_pkg::SIZE_REG2;
					end
					rme_pkg::MODE_MOD, rme_pkg::MODE_DIV: begin
						// A zero divisor leaves the accumulator as it is.
						md_req.op = (mode_q == rme_pkg::MODE_DIV) ? rme_pkg::MD_DIV
						                                          : rme_pkg::MD_MOD;
						if (b != '0) begin
							md_req.start = 1'b1;
							state_d      = S_WAIT;
						end
						pc_d = pc_q + rme_pkg::SIZE_REG2;
					end
					rme_pkg::MODE_INC: begin
						wr_en   = 1'b1;
						wr_data = a + 1'b1;
						pc_d    = pc_q + rme_pkg::SIZE_REG1;
					end
					rme_pkg::MODE_DEC: begin
						wr_en   = 1'b1;
						wr_data = a - 1'b1;
						pc_d    = pc_q + rme_pkg::SIZE_REG1;
					end
					rme_pkg::MODE_EQ: begin
						wr_en   = 1'b1;
						wr_idx  = '0;
						wr_data = W'(a == b);
						pc_d    = pc_q + rme_pkg::SIZE_REG2;
					end
					rme_pkg::MODE_GE: begin
						wr_en   = 1'b1;
						wr_idx  = '0;
						wr_data = W'($signed(a) >= $signed(b));
						pc_d    = pc_q + rme_pkg::SIZE_REG2;
					end
					rme_pkg::MODE_LE: begin
						wr_en   = 1'b1;
						wr_idx  = '0;
						wr_data = W'($signed(a) <= $signed(b));
						pc_d    = pc_q + rme_pkg::SIZE_REG2;
					end
					rme_pkg::MODE_GOTO: begin
						pc_d = code_base_q + a;
					end
					rme_pkg::MODE_JZ: begin
						pc_d = (acc_q == '0) ? (code_base_q + imm_q)
						                     : (pc_q + rme_pkg::SIZE_JUMP);
					end
					rme_pkg::MODE_JNZ: begin
						pc_d = (acc_q != '0) ? (code_base_q + imm_q)
						                     : (pc_q + rme_pkg::SIZE_JUMP);
					end
					rme_pkg::MODE_SHIFT: begin
						wr_en   = 1'b1;
						wr_idx  = r2_q;
						wr_data = shift_val;
						pc_d    = pc_q + rme_pkg::SIZE_LONG;
					end
					rme_pkg::MODE_NOP: begin
						pc_d = pc_q + rme_pkg::SIZE_SHORT;
					end
					rme_pkg::MODE_END: begin
						status_d = rme_pkg::ST_END;
					end
					rme_pkg::MODE_INT: begin
						status_d = rme_pkg::ST_INT;
						iaddr_d  = imm_q;
						pc_d     = pc_q + rme_pkg::SIZE_JUMP;
					end
					default: begin
					end
				endcase
			end
			S_WAIT: begin
				if (md_rsp.done) begin
					wr_en   = 1'b1;
					wr_idx  = '0;
					wr_data = md_rsp.result;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_base_q <= '0;
			pc_q        <= '0;
			acc_q       <= '0;
			status_q    <= rme_pkg::ST_CONT;
			iaddr_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				code_base_q <= cfg_data;
			end
			// Register 0 is mirrored here so the jump tests and the result see it directly.
			if (wr_en && wr_idx == '0) begin
				acc_q <= wr_data;
			end
			if (state_q == S_EXEC) begin
				pc_q     <= pc_d;
				status_q <= status_d;
				iaddr_q  <= iaddr_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			r1_q   <= first_reg;
			r2_q   <= second_reg;
			imm_q  <= immediate;
		end
	end

	assign out_valid         = (state_q == S_OUT);
	assign status            = status_q;
	assign next_pc           = pc_q;
	assign accumulator       = $signed(acc_q);
	assign interrupt_address = iaddr_q;

endmodule

### rtl/rme_checker.sv
module rme_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [rme_pkg::STATUS_W-1:0]      status,
	input logic [rme_pkg::DATA_W-1:0]        next_pc,
	input logic [rme_pkg::DATA_W-1:0]        interrupt_address
);

	// Only one instruction is in flight at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an instruction is in flight");

	a_no_input_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result is pending");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(status))
		else $error("stalled result changed");

	a_iaddr_only_on_int: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rme_pkg::ST_INT |-> interrupt_address == '0)
		else $error("interrupt address set without an interrupt");

endmodule

bind register_machine_execute_unit_top rme_checker u_rme_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.status           (status),
	.next_pc          (next_pc),
	.interrupt_address(interrupt_address)
);

### tb/execute_unit_checker.sv
module execute_unit_checker #(
	parameter int REG_COUNT = rme_pkg::REG_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [rme_pkg::DATA_W-1:0]         cfg_data,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [rme_pkg::MODE_W-1:0]         mode,
	input  logic [rme_pkg::REG_IDX_W-1:0]      first_reg,
	input  logic [rme_pkg::REG_IDX_W-1:0]      second_reg,
	input  logic signed [rme_pkg::DATA_W-1:0]  immediate,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic [rme_pkg::STATUS_W-1:0]       status,
	input  logic [rme_pkg::DATA_W-1:0]         next_pc,
	input  logic signed [rme_pkg::DATA_W-1:0]  accumulator,
	input  logic [rme_pkg::DATA_W-1:0]         interrupt_address,
	output int                                 results_owed,
	output int                                 mismatch_count
);

	localparam int DW = rme_pkg::DATA_W;

	localparam logic [rme_pkg::REG_IDX_W-1:0] ACC_IDX = '0;
	localparam logic [DW-1:0] MOST_NEG = 32'h8000_0000;
	localparam logic [DW-1:0] MINUS_ONE = '1;

	typedef struct packed {
		logic [rme_pkg::MODE_W-1:0]    mode;
		logic [rme_pkg::REG_IDX_W-1:0] r1;
		logic [rme_pkg::REG_IDX_W-1:0] r2;
		logic [DW-1:0]                 imm;
	} instr_t;

	typedef struct packed {
		logic [rme_pkg::STATUS_W-1:0] status;
		logic [DW-1:0]                pc;
		logic [DW-1:0]                acc;
		logic [DW-1:0]                iaddr;
	} outcome_t;

	logic [DW-1:0] shadow_regs [0:REG_COUNT-1];
	logic [DW-1:0] shadow_pc;
	logic [DW-1:0] shadow_code_base;
	outcome_t      owed_outcomes [$];

	// Indexes past the end of the register file read as zero and swallow writes.
	function automatic logic [DW-1:0] reg_read(logic [rme_pkg::REG_IDX_W-1:0] idx);
		if (idx < REG_COUNT) begin
			return shadow_regs[idx];
		end
		return '0;
	endfunction

	function automatic void reg_write(logic [rme_pkg::REG_IDX_W-1:0] idx, logic [DW-1:0] v);
		if (idx < REG_COUNT) begin
			shadow_regs[idx] = v;
		end
	endfunction

	function automatic outcome_t execute_instr(instr_t ins);
		logic [DW-1:0] a;
		logic [DW-1:0] b;
		logic [DW-1:0] q;
		logic [DW-1:0] r;
		logic [DW-1:0] v;
		logic [DW-1:0] n;
		logic [DW-1:0] pc_n;
		outcome_t res;
		a = reg_read(ins.r1);
		b = reg_read(ins.r2);
		pc_n = shadow_pc;
		res.status = rme_pkg::ST_CONT;
		res.iaddr = '0;
		case (ins.mode)
			rme_pkg::MODE_LOAD: begin
				reg_write(ins.r1, ins.imm);
				pc_n += rme_pkg::SIZE_LONG;
			end
			rme_pkg::MODE_MOV: begin
				reg_write(ins.r1, b);
				pc_n += rme_pkg::SIZE_REG2;
			end
			rme_pkg::MODE_ADD: begin
				reg_write(ACC_IDX, a + b);
				pc_n += rme_pkg::SIZE_REG2;
			end
			rme_pkg::MODE_SUB: begin
				reg_write(ACC_IDX, a - b);
				pc_n += rme_pkg::SIZE_REG2;
			end
			rme_pkg::MODE_MUL: begin
				reg_write(ACC_IDX, a * b);
				pc_n += rme_pkg::SIZE_REG2;
			end
			rme_pkg::MODE_MOD, rme_pkg::MODE_DIV: begin
				// A zero divisor leaves the accumulator alone.
				if (b != '0) begin
					if (a == MOST_NEG && b == MINUS_ONE) begin
						q = MOST_NEG;
						r = '0;
					end else begin
						q = $signed(a) / $signed(b);
						r = $signed(a) % $signed(b);
					end
					reg_write(ACC_IDX, (ins.mode == rme_pkg::MODE_DIV) ? q : r);
				end
				pc_n += rme_pkg::SIZE_REG2;
			end
			rme_pkg::MODE_INC: begin
				reg_write(ins.r1, a + 1);
				pc_n += rme_pkg::SIZE_REG1;
			end
			rme_pkg::MODE_DEC: begin
				reg_write(ins.r1, a - 1);
				pc_n += rme_pkg::SIZE_REG1;
			end
			rme_pkg::MODE_EQ: begin
				reg_write(ACC_IDX, ($signed(a) == $signed(b)) ? 32'd1 : 32'd0);
				pc_n += rme_pkg::SIZE_REG2;
			end
			rme_pkg::MODE_GE: begin
				reg_write(ACC_IDX, ($signed(a) >= $signed(b)) ? 32'd1 : 32'd0);
				pc_n += rme_pkg::SIZE_REG2;
			end
			rme_pkg::MODE_LE: begin
				reg_write(ACC_IDX, ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0);
				pc_n += rme_pkg::SIZE_REG2;
			end
			rme_pkg::MODE_GOTO: begin
				pc_n = shadow_code_base + a;
			end
			rme_pkg::MODE_JZ: begin
				if (reg_read(ACC_IDX) == '0) begin
					pc_n = shadow_code_base + ins.imm;
				end else begin
					pc_n += rme_pkg::SIZE_JUMP;
				end
			end
			rme_pkg::MODE_JNZ: begin
				if (reg_read(ACC_IDX) != '0) begin
					pc_n = shadow_code_base + ins.imm;
				end else begin
					pc_n += rme_pkg::SIZE_JUMP;
				end
			end
			rme_pkg::MODE_SHIFT: begin
				// Positive counts shift right, negative counts shift left.
				v = b;
				if (ins.imm != '0) begin
					if (!ins.imm[DW-1]) begin
						v = (ins.imm >= DW) ? '0 : (b >> ins.imm);
					end else begin
						n = -ins.imm;
						v = (n >= DW) ? '0 : (b << n);
					end
				end
				reg_write(ins.r2, v);
				pc_n += rme_pkg::SIZE_LONG;
			end
			rme_pkg::MODE_NOP: begin
				pc_n += rme_pkg::SIZE_SHORT;
			end
			rme_pkg::MODE_END: begin
				res.status = rme_pkg::ST_END;
			end
			rme_pkg::MODE_INT: begin
				res.status = rme_pkg::ST_INT;
				res.iaddr = ins.imm;
				pc_n += rme_pkg::SIZE_JUMP;
			end
			default: begin
			end
		endcase
		shadow_pc = pc_n;
		res.pc = pc_n;
		res.acc = reg_read(ACC_IDX);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		instr_t   ins;
		outcome_t want;
		int       errs;
		if (!arst_n) begin
			foreach (shadow_regs[i]) begin
				shadow_regs[i] = '0;
			end
			shadow_pc = '0;
			shadow_code_base = '0;
			owed_outcomes.delete();
			results_owed <= 0;
			mismatch_count <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				shadow_code_base = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (owed_outcomes.size() == 0) begin
					$error("result transaction with no instruction outstanding");
					errs++;
				end else begin
					want = owed_outcomes.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						errs++;
					end
					if (next_pc !== want.pc) begin
						$error("next_pc: expected %0h, actual %0h", want.pc, next_pc);
						errs++;
					end
					if (accumulator !== want.acc) begin
						$error("accumulator: expected %0d, actual %0d",
							$signed(want.acc), accumulator);
						errs++;
					end
					if (interrupt_address !== want.iaddr) begin
						$error("interrupt_address: expected %0h, actual %0h",
							want.iaddr, interrupt_address);
						errs++;
					end
				end
			end
			if (in_valid && in_ready) begin
				ins.mode = mode;
				ins.r1 = first_reg;
				ins.r2 = second_reg;
				ins.imm = immediate;
				owed_outcomes.push_back(execute_instr(ins));
			end
			results_owed <= owed_outcomes.size();
			mismatch_count <= mismatch_count + errs;
		end
	end

endmodule

### tb/tb_register_machine_execute_unit_top.sv
module tb_register_machine_execute_unit_top;

	localparam int REG_COUNT = rme_pkg::REG_COUNT_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int DW = rme_pkg::DATA_W;

	typedef logic [rme_pkg::REG_IDX_W-1:0] reg_idx_t;
	typedef logic [rme_pkg::MODE_W-1:0]    mode_t;

	localparam reg_idx_t ACC = 3'd0;
	localparam reg_idx_t RB = 3'd1;
	localparam reg_idx_t RC = 3'd2;
	localparam reg_idx_t RD = 3'd3;
	localparam reg_idx_t RE = 3'd4;
	localparam reg_idx_t NOREG5 = 3'd5;
	localparam reg_idx_t NOREG6 = 3'd6;
	localparam reg_idx_t NOREG7 = 3'd7;
	localparam mode_t MODE_UNUSED = '1;
	localparam logic [DW-1:0] MOST_NEG = 32'h8000_0000;
	localparam logic [DW-1:0] MOST_POS = 32'h7FFF_FFFF;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [DW-1:0]                      cfg_data;
	logic                               in_valid;
	logic                               in_ready;
	mode_t                              mode;
	reg_idx_t                           first_reg;
	reg_idx_t                           second_reg;
	logic signed [DW-1:0]               immediate;
	logic                               out_valid;
	logic                               out_ready;
	logic [rme_pkg::STATUS_W-1:0]       status;
	logic [DW-1:0]                      next_pc;
	logic signed [DW-1:0]               accumulator;
	logic [DW-1:0]                      interrupt_address;
	int                                 results_owed;
	int                                 mismatch_count;

	bit                                 hold_req;
	bit                                 tail_quiet;
	int                                 tx_idle_pct;
	int                                 rx_stall_pct;

	register_machine_execute_unit_top #(
		.REG_COUNT(REG_COUNT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.first_reg(first_reg),
		.second_reg(second_reg),
		.immediate(immediate),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.next_pc(next_pc),
		.accumulator(accumulator),
		.interrupt_address(interrupt_address)
	);

	execute_unit_checker #(
		.REG_COUNT(REG_COUNT)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.first_reg(first_reg),
		.second_reg(second_reg),
		.immediate(immediate),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.next_pc(next_pc),
		.accumulator(accumulator),
		.interrupt_address(interrupt_address),
		.results_owed(results_owed),
		.mismatch_count(mismatch_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Result side: random stall bursts, plus one long hold-off on request so that
	// the block backs up into its input.
	initial begin : receiver
		int n;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!tail_quiet && $urandom_range(0, 99) < rx_stall_pct) begin
				n = $urandom_range(1, 10);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	task automatic issue(input mode_t m, input reg_idx_t r1,
		input reg_idx_t r2, input logic [DW-1:0] imm);
		int gap;
		if (!tail_quiet && $urandom_range(0, 99) < tx_idle_pct) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		first_reg <= r1;
		second_reg <= r2;
		immediate <= imm;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Drains the block before a register write. Every instruction returns a result,
	// so the task waits until no result is owed and then writes the code base.
	task automatic set_code_base(input logic [DW-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [DW-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return MOST_NEG;
			2: return MOST_POS;
			3: return '1;
			4: return $urandom_range(0, 20);
			5: return -$urandom_range(1, 20);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [DW-1:0] pick_shift_count();
		case ($urandom_range(0, 5))
			0, 1: return $urandom_range(0, 40);
			2, 3: return -$urandom_range(1, 40);
			4: return MOST_NEG;
			default: return $urandom();
		endcase
	endfunction

	function automatic reg_idx_t pick_reg();
		if ($urandom_range(0, 9) == 0) begin
			return reg_idx_t'($urandom_range(REG_COUNT, 7));
		end
		return reg_idx_t'($urandom_range(0, REG_COUNT - 1));
	endfunction

	task automatic random_instr();
		mode_t             m;
		logic [DW-1:0]     imm;
		int                k;
		k = $urandom_range(0, 99);
		if (k < 4) begin
			m = mode_t'($urandom_range(rme_pkg::MODE_INT + 1, MODE_UNUSED));
		end else if (k < 22) begin
			m = rme_pkg::MODE_LOAD;
		end else begin
			m = mode_t'($urandom_range(rme_pkg::MODE_LOAD, rme_pkg::MODE_INT));
		end
		case (m)
			rme_pkg::MODE_LOAD: imm = pick_value();
			rme_pkg::MODE_SHIFT: imm = pick_shift_count();
			default: imm = $urandom();
		endcase
		issue(m, pick_reg(), pick_reg(), imm);
	endtask

	task automatic random_run(input int count);
		repeat (count) random_instr();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = '0;
		first_reg = '0;
		second_reg = '0;
		immediate = '0;
		hold_req = 1'b0;
		tail_quiet = 1'b0;
		tx_idle_pct = 20;
		rx_stall_pct = 20;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_code_base('0);
		// Signed overflow of division, zero divisors, wrap-around and the edges of
		// the shift count come first.
		issue(rme_pkg::MODE_LOAD, RB, ACC, MOST_NEG);
		issue(rme_pkg::MODE_LOAD, RC, ACC, '1);
		issue(rme_pkg::MODE_DIV, RB, RC, '0);
		issue(rme_pkg::MODE_MOD, RB, RC, '0);
		issue(rme_pkg::MODE_LOAD, RD, ACC, '0);
		issue(rme_pkg::MODE_LOAD, ACC, ACC, 32'd7);
		issue(rme_pkg::MODE_DIV, RB, RD, '0);
		issue(rme_pkg::MODE_MOD, RC, RD, '0);
		issue(rme_pkg::MODE_LOAD, RE, ACC, MOST_POS);
		issue(rme_pkg::MODE_ADD, RE, RC, '0);
		issue(rme_pkg::MODE_SUB, RB, RE, '0);
		issue(rme_pkg::MODE_MUL, RE, RE, '0);
		issue(rme_pkg::MODE_MOV, ACC, RB, '0);
		issue(rme_pkg::MODE_INC, RE, ACC, '0);
		issue(rme_pkg::MODE_DEC, RD, ACC, '0);
		issue(rme_pkg::MODE_EQ, RC, RD, '0);
		issue(rme_pkg::MODE_GE, RB, RE, '0);
		issue(rme_pkg::MODE_LE, RB, RC, '0);
		issue(rme_pkg::MODE_GOTO, RC, ACC, '0);
		issue(rme_pkg::MODE_JZ, ACC, ACC, 32'h0000_0100);
		issue(rme_pkg::MODE_JNZ, ACC, ACC, 32'hFFFF_FFF0);
		issue(rme_pkg::MODE_SHIFT, ACC, RC, 32'd32);
		issue(rme_pkg::MODE_SHIFT, ACC, RD, MOST_NEG);
		issue(rme_pkg::MODE_SHIFT, ACC, RD, '1);
		issue(rme_pkg::MODE_SHIFT, ACC, RC, '0);
		issue(rme_pkg::MODE_NOP, ACC, ACC, '0);
		issue(rme_pkg::MODE_END, ACC, ACC, '0);
		issue(rme_pkg::MODE_INT, ACC, ACC, 32'hDEAD_BEEF);
		issue(MODE_UNUSED, NOREG7, NOREG6, '1);
		issue(rme_pkg::MODE_LOAD, NOREG7, ACC, 32'd5);
		issue(rme_pkg::MODE_MOV, ACC, NOREG5, '0);

		set_code_base('1);
		random_run(250);

		set_code_base(MOST_NEG);
		hold_req <= 1'b1;
		random_run(250);

		set_code_base($urandom());
		tx_idle_pct = 0;
		rx_stall_pct = 40;
		random_run(250);

		set_code_base(32'h0000_1000);
		tx_idle_pct = 40;
		rx_stall_pct = 0;
		random_run(250);

		set_code_base('0);
		tail_quiet = 1'b1;
		random_run(350);

		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/rme_pkg.sv
rtl/rme_regfile.sv
rtl/rme_muldiv.sv
rtl/register_machine_execute_unit_top.sv
rtl/rme_checker.sv
tb/execute_unit_checker.sv
tb/tb_register_machine_execute_unit_top.sv
